/* hdl/i2cm_pkg.sv */
// Package for the I2C master transfer engine: phase, stage, operation and status codes.
// No dependencies.
package i2cm_pkg;

  localparam int WriteDepthDef = 16;

  typedef enum logic [3:0] {
    PH_IDLE, PH_REC_CHECK, PH_REC_LOW, PH_REC_HIGH, PH_START_A, PH_START_B,
    PH_START_C, PH_BIT_A, PH_BIT_B, PH_BIT_C, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  typedef enum logic [2:0] {
    ST_REC, ST_WADDR, ST_WDATA, ST_RADDR, ST_RDATA
  } stage_t;

  typedef enum logic [1:0] {
    OP_TICK, OP_PUSH, OP_XFER, OP_RECOVER
  } op_t;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_NACK    = 3'd1;
  localparam logic [2:0] STAT_INVALID = 3'd2;
  localparam logic [2:0] STAT_BUSY    = 3'd3;
  localparam logic [2:0] STAT_NREADY  = 3'd4;

  localparam logic [15:0] HALF_DEF = 16'd5;
  localparam logic [7:0]  PULSE_DEF = 8'd9;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rdata;
    logic       rvalid;
    logic       busy;
    logic       done;
    logic [2:0] status;
  } result_t;

  // Configuration register indexes.
  localparam logic REG_HALF = 1'b0;
  localparam logic REG_PULSE = 1'b1;

endpackage

/* hdl/i2cm_cfg.sv */
// APB-style configuration registers for the I2C master engine.
// Depends on i2cm_pkg.
module i2cm_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] half_period,
  output logic [7:0]  recovery_clocks
);
  import i2cm_pkg::*;

  logic [15:0] half_r;
  logic [7:0]  pulse_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_DEF;
      pulse_r <= PULSE_DEF;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_HALF) half_r <= pwdata[15:0];
      else pulse_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_HALF) prdata = {16'd0, half_r};
      else prdata = {24'd0, pulse_r};
    end
  end

  // A stored zero behaves as the default value.
  assign half_period     = (half_r == '0) ? HALF_DEF : half_r;
  assign recovery_clocks = (pulse_r == '0) ? PULSE_DEF : pulse_r;

endmodule

/* hdl/i2cm_seq.sv */
// Bus sequencer of the I2C master engine: one request is processed per cycle
// while step is high, into a result register. Depends on i2cm_pkg.
module i2cm_seq #(
  parameter int WRITE_DEPTH = i2cm_pkg::WriteDepthDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [1:0]             operation,
  input  logic                   sda_in,
  input  logic                   scl_in,
  input  logic [6:0]             address,
  input  logic [4:0]             write_length,
  input  logic [15:0]            read_length,
  input  logic [7:0]             write_byte,
  input  logic [15:0]            half_period,
  input  logic [7:0]             recovery_clocks,
  output i2cm_pkg::result_t      res
);
  import i2cm_pkg::*;

  localparam int QW = $clog2(WRITE_DEPTH + 1);
  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [15:0] dly_r, dly_nxt, bytes_r, bytes_nxt, reads_r, reads_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  sh_r, sh_nxt, pulse_r, pulse_nxt;
  logic [QW-1:0] fill_r, fill_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [4:0]  wleft_r, wleft_nxt;
  logic        init_r, init_nxt, xfer_r, xfer_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        scl_r, scl_nxt, sda_r, sda_nxt;
  result_t     out_nxt;
  logic [7:0]  wq [WRITE_DEPTH];
  logic        wq_we;
  logic        busy, exp_d;
  logic [15:0] dcnt;

  assign wq_we = step && operation == OP_PUSH && phase_r == PH_IDLE &&
                 32'(fill_r) < WRITE_DEPTH;
  always_ff @(posedge clk) begin
    if (wq_we) wq[fill_r[AW-1:0]] <= write_byte;
  end

  assign busy = phase_r != PH_IDLE;
  assign dcnt = (dly_r != '0) ? dly_r - 16'd1 : dly_r;
  assign exp_d = dcnt == '0;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] rl;
    logic [4:0]  wl;
    logic [7:0]  pc;
    logic        begin_b, go_start, go_stop, fin, body;
    phase_nxt = phase_r; stage_nxt = stage_r; dly_nxt = dly_r;
    bytes_nxt = bytes_r; reads_nxt = reads_r; bit_nxt = bit_r;
    sh_nxt = sh_r; pulse_nxt = pulse_r; fill_nxt = fill_r; addr_nxt = addr_r;
    wleft_nxt = wleft_r; init_nxt = init_r; xfer_nxt = xfer_r; pend_nxt = pend_r;
    scl_nxt = scl_r; sda_nxt = sda_r;
    out_nxt = '0;
    begin_b = 1'b0; go_start = 1'b0; go_stop = 1'b0; fin = 1'b0; body = 1'b0;
    b = '0; rl = reads_r; wl = wleft_r; pc = '0;
    case (operation)
      OP_TICK: begin
        if (busy) begin
          dly_nxt = dcnt;
          if (exp_d) begin
            dly_nxt = half_period;
            case (phase_r)
              PH_REC_CHECK: begin
                if (sda_in && scl_in) begin
                  if (xfer_r) body = 1'b1;
                  else fin = 1'b1;
                end else begin
                  pulse_nxt = '0; scl_nxt = 1'b0; phase_nxt = PH_REC_LOW;
                end
              end
              PH_REC_LOW: begin
                scl_nxt = 1'b1; phase_nxt = PH_REC_HIGH;
              end
              PH_REC_HIGH: begin
                pc = pulse_r + 8'd1;
                if (sda_in) go_stop = 1'b1;
                else begin
                  pulse_nxt = pc;
                  if (pc >= recovery_clocks) go_stop = 1'b1;
                  else begin
                    scl_nxt = 1'b0; phase_nxt = PH_REC_LOW;
                  end
                end
              end
              PH_START_A: begin sda_nxt = 1'b0; phase_nxt = PH_START_B; end
              PH_START_B: begin scl_nxt = 1'b0; phase_nxt = PH_START_C; end
              PH_START_C: begin_b = 1'b1;
              PH_BIT_A: begin scl_nxt = 1'b1; phase_nxt = PH_BIT_B; end
              PH_BIT_B: begin
                if (!bit_r[3] && stage_r == ST_RDATA) begin
                  sh_nxt = {sh_r[6:0], sda_in};
                  if (bit_r == 4'd7) begin
                    out_nxt.rdata = {sh_r[6:0], sda_in};
                    out_nxt.rvalid = 1'b1;
                  end
                end else if (bit_r[3] && stage_r != ST_RDATA && sda_in) begin
                  pend_nxt = STAT_NACK;
                end
                scl_nxt = 1'b0; phase_nxt = PH_BIT_C;
              end
              PH_BIT_C: begin
                if (!bit_r[3]) begin
                  if (stage_r != ST_RDATA) sh_nxt = {sh_r[6:0], 1'b0};
                  bit_nxt = bit_r + 4'd1;
                  // Next level: data bit, or acknowledge slot.
                  if (bit_r != 4'd7) sda_nxt = (stage_r == ST_RDATA) ? 1'b1 : sh_r[6];
                  else if (stage_r == ST_RDATA) sda_nxt = !(reads_r > 16'd1);
                  else sda_nxt = 1'b1;
                  phase_nxt = PH_BIT_A;
                end else if (pend_r != STAT_OK) begin
                  go_stop = 1'b1;
                end else begin
                  case (stage_r)
                    ST_WADDR: begin stage_nxt = ST_WDATA; begin_b = 1'b1; end
                    ST_WDATA: begin
                      bytes_nxt = bytes_r + 16'd1;
                      wl = (wleft_r != '0) ? wleft_r - 5'd1 : wleft_r;
                      wleft_nxt = wl;
                      if (wl != '0) begin_b = 1'b1;
                      else if (reads_r != '0) begin
                        stage_nxt = ST_RADDR; go_start = 1'b1;
                      end else go_stop = 1'b1;
                    end
                    ST_RADDR: begin stage_nxt = ST_RDATA; begin_b = 1'b1; end
                    default: begin
                      rl = (reads_r != '0) ? reads_r - 16'd1 : reads_r;
                      reads_nxt = rl;
                      if (rl != '0) begin_b = 1'b1;
                      else go_stop = 1'b1;
                    end
                  endcase
                end
              end
              PH_STOP_A: begin scl_nxt = 1'b1; phase_nxt = PH_STOP_B; end
              PH_STOP_B: begin sda_nxt = 1'b1; phase_nxt = PH_STOP_C; end
              PH_STOP_C: begin
                if (xfer_r && stage_r == ST_REC) body = 1'b1;
                else fin = 1'b1;
              end
              default: begin phase_nxt = PH_IDLE; dly_nxt = '0; end
            endcase
          end
        end
      end
      OP_PUSH: begin
        out_nxt.done = 1'b1;
        if (busy) out_nxt.status = STAT_BUSY;
        else if (32'(fill_r) >= WRITE_DEPTH) out_nxt.status = STAT_INVALID;
        else fill_nxt = fill_r + QW'(1);
      end
      OP_XFER: begin
        if ((write_length == '0 && read_length == '0) ||
            32'(write_length) > 32'(fill_r)) begin
          out_nxt.done = 1'b1; out_nxt.status = STAT_INVALID;
        end else if (!init_r) begin
          out_nxt.done = 1'b1; out_nxt.status = STAT_NREADY;
        end else if (busy) begin
          out_nxt.done = 1'b1; out_nxt.status = STAT_BUSY;
        end else begin
          addr_nxt = address; wleft_nxt = write_length; reads_nxt = read_length;
          bytes_nxt = '0; pulse_nxt = '0; pend_nxt = STAT_OK; xfer_nxt = 1'b1;
          stage_nxt = ST_REC; sda_nxt = 1'b1; scl_nxt = 1'b1;
          phase_nxt = PH_REC_CHECK; dly_nxt = half_period;
        end
      end
      default: begin
        if (busy) begin
          out_nxt.done = 1'b1; out_nxt.status = STAT_BUSY;
        end else begin
          pulse_nxt = '0; pend_nxt = STAT_OK; xfer_nxt = 1'b0; stage_nxt = ST_REC;
          sda_nxt = 1'b1; scl_nxt = 1'b1;
          phase_nxt = PH_REC_CHECK; dly_nxt = half_period;
        end
      end
    endcase

    if (body) begin
      stage_nxt = (wleft_r != '0) ? ST_WADDR : ST_RADDR;
      go_start = 1'b1;
    end
    if (go_start) begin
      sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = PH_START_A;
    end
    if (go_stop) begin
      sda_nxt = 1'b0; phase_nxt = PH_STOP_A;
    end
    if (begin_b) begin
      bit_nxt = '0;
      case (stage_nxt)
        ST_WADDR: b = {addr_r, 1'b0};
        ST_RADDR: b = {addr_r, 1'b1};
        ST_WDATA: b = (32'(bytes_nxt) < WRITE_DEPTH) ?
                      wq[bytes_nxt[AW-1:0]] : 8'd0;
        default:  b = '0;
      endcase
      sh_nxt = b;
      sda_nxt = (stage_nxt == ST_RDATA) ? 1'b1 : b[7];
      phase_nxt = PH_BIT_A;
    end
    if (fin) begin
      phase_nxt = PH_IDLE; dly_nxt = '0;
      out_nxt.done = 1'b1; out_nxt.status = pend_r;
      if (xfer_r) fill_nxt = '0;
      else init_nxt = 1'b1;
      xfer_nxt = 1'b0;
    end
    out_nxt.scl = scl_nxt;
    out_nxt.sda = sda_nxt;
    out_nxt.busy = phase_nxt != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; stage_r <= ST_REC; dly_r <= '0; bytes_r <= '0;
      reads_r <= '0; bit_r <= '0; sh_r <= '0; pulse_r <= '0; fill_r <= '0;
      addr_r <= '0; wleft_r <= '0; init_r <= 1'b0; xfer_r <= 1'b0;
      pend_r <= STAT_OK; scl_r <= 1'b1; sda_r <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt; stage_r <= stage_nxt; dly_r <= dly_nxt;
      bytes_r <= bytes_nxt; reads_r <= reads_nxt; bit_r <= bit_nxt;
      sh_r <= sh_nxt; pulse_r <= pulse_nxt; fill_r <= fill_nxt;
      addr_r <= addr_nxt; wleft_r <= wleft_nxt; init_r <= init_nxt;
      xfer_r <= xfer_nxt; pend_r <= pend_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= out_nxt;
  end

  ap_fill: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= WRITE_DEPTH) else $error("queue fill beyond depth");
  ap_idle_delay: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> dly_r == '0) else $error("delay running while idle");
  ap_xfer_init: assert property (@(posedge clk) disable iff (!rst_n)
    xfer_r |-> init_r) else $error("transfer without recovery");
  ap_bit: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8) else $error("bit index out of range");

endmodule

/* hdl/i2c_master_transfer_engine_core.sv */
// Top level of the I2C master transfer engine: handshakes, result register.
// Depends on i2cm_pkg, i2cm_cfg and i2cm_seq.
//
//   channel | direction | handshake
//   in_*    | input     | in_valid / in_ready
//   out_*   | output    | out_valid / out_ready
//   p*      | APB r/w   | psel, penable, pwrite, pready
//
// Each request is processed combinationally; its result appears the next cycle.
// A new request is taken every cycle while the result register is empty or
// being drained. Reset is synchronous; it clears the sequencer, empties the
// queue and loads half_period 5 and recovery_clocks 9.
module i2c_master_transfer_engine_core #(
  parameter int WRITE_DEPTH = i2cm_pkg::WriteDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_sda_in,
  input  logic        in_scl_in,
  input  logic [6:0]  in_address,
  input  logic [4:0]  in_write_length,
  input  logic [15:0] in_read_length,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_drive,
  output logic        out_sda_drive,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_engine_busy,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cm_pkg::*;

  logic        step, valid_r;
  logic [15:0] half_period;
  logic [7:0]  recovery_clocks;
  result_t     res;

  assign in_ready = !valid_r || out_ready;
  assign step = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_ready) valid_r <= in_valid;
  end
  assign out_valid = valid_r;

  i2cm_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .half_period, .recovery_clocks
  );

  i2cm_seq #(.WRITE_DEPTH(WRITE_DEPTH)) u_seq (
    .clk, .rst_n, .step,
    .operation(in_operation), .sda_in(in_sda_in), .scl_in(in_scl_in),
    .address(in_address), .write_length(in_write_length),
    .read_length(in_read_length), .write_byte(in_write_byte),
    .half_period, .recovery_clocks, .res
  );

  assign out_scl_drive   = res.scl;
  assign out_sda_drive   = res.sda;
  assign out_read_data   = res.rdata;
  assign out_read_valid  = res.rvalid;
  assign out_engine_busy = res.busy;
  assign out_done_res    = res.done;
  assign out_status      = res.status;

endmodule
